// File: rtl/m4vt_pkg.sv
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types and constants for the 4x4 matrix-vector transform: fixed-point
// word types, matrix and coefficient layouts, pipeline depth, register resets.
// ----------------------------------------------------------------------------
package m4vt_pkg;

  // word and matrix geometry
  localparam int FIX_W       = 32;
  localparam int COMP_COUNT  = 4;
  localparam int ENTRY_COUNT = COMP_COUNT * COMP_COUNT;

  // configuration register file
  localparam int PAIR_COUNT = 8;
  localparam int PAIR_W     = 2 * FIX_W;
  localparam int PAIR_IDX_W = 3;
  localparam int CFG_IDX_W  = 4;

  // datapath widths: product, pair sum, full four-term sum
  localparam int PROD_W     = 2 * FIX_W;
  localparam int PAIR_SUM_W = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;

  // register stages from input register to output register
  localparam int STAGE_COUNT = 5;

  typedef logic signed [FIX_W-1:0]      fix_t;
  typedef fix_t [COMP_COUNT-1:0]        vec_t;
  typedef vec_t [COMP_COUNT-1:0]        coef_t;
  typedef fix_t [ENTRY_COUNT-1:0]       matrix_t;
  typedef logic [PAIR_W-1:0]            pair_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [PAIR_SUM_W-1:0] pair_sum_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
  localparam fix_t FIX_MIN = 32'sh8000_0000;

  // identity matrix, two entries per register
  localparam pair_t PAIR_RESET [PAIR_COUNT] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

endpackage

// File: rtl/m4vt_cfg_regs.sv
// ----------------------------------------------------------------------------
// m4vt_cfg_regs
// Matrix register file: eight 64-bit registers, each holding two Q16.16
// entries, presented as a row-major array of sixteen entries.
// ----------------------------------------------------------------------------
module m4vt_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [m4vt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  m4vt_pkg::pair_t                      cfg_data,
  output m4vt_pkg::matrix_t                    entries
);
  import m4vt_pkg::*;

  pair_t pairs [PAIR_COUNT];

  // register writes, indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PAIR_COUNT; p++) begin
        pairs[p] <= PAIR_RESET[p];
      end
    end else if (cfg_write && (cfg_index < CFG_IDX_W'(PAIR_COUNT))) begin
      pairs[cfg_index[PAIR_IDX_W-1:0]] <= cfg_data;
    end
  end

  // low half is the even entry, high half the odd one
  always_comb begin
    for (int p = 0; p < PAIR_COUNT; p++) begin
      entries[2*p]     = pairs[p][FIX_W-1:0];
      entries[2*p + 1] = pairs[p][PAIR_W-1:FIX_W];
    end
  end

endmodule

// File: rtl/m4vt_dot_lane.sv
// ----------------------------------------------------------------------------
// m4vt_dot_lane
// One output component: four-stage dot product of the vector with one
// coefficient vector (a matrix row or column), then floor shift by the fraction width and saturation.
// ----------------------------------------------------------------------------
module m4vt_dot_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             advance,
  input  m4vt_pkg::vec_t   vec,
  input  m4vt_pkg::vec_t   coef,
  output m4vt_pkg::fix_t   res,
  output logic             sat
);
  import m4vt_pkg::*;

  prod_t     prod [COMP_COUNT];
  pair_sum_t psum [COMP_COUNT/2];
  sum_t      total;
  sum_t      shifted;
  logic      over_pos;
  logic      over_neg;

  // stage 1: four signed products
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < COMP_COUNT; i++) begin
        prod[i] <= $signed(vec[i]) * $signed(coef[i]);
      end
    end
  end

  // stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < COMP_COUNT/2; j++) begin
        psum[j] <= PAIR_SUM_W'(prod[2*j]) + PAIR_SUM_W'(prod[2*j + 1]);
      end
    end
  end

  // stage 3: full-width sum
  always_ff @(posedge clk) begin
    if (advance) begin
      total <= SUM_W'(psum[0]) + SUM_W'(psum[1]);
    end
  end

  // floor shift and range check against the 32-bit word
  always_comb begin
    shifted  = total >>> FRAC_BITS;
    over_pos = !shifted[SUM_W-1] && (|shifted[SUM_W-1:FIX_W-1]);
    over_neg = shifted[SUM_W-1] && !(&shifted[SUM_W-1:FIX_W-1]);
  end

  // stage 4: clipped result word
  always_ff @(posedge clk) begin
    if (advance) begin
      if (over_pos) begin
        res <= FIX_MAX;
      end else if (over_neg) begin
        res <= FIX_MIN;
      end else begin
        res <= shifted[FIX_W-1:0];
      end
      sat <= over_pos || over_neg;
    end
  end

endmodule

// File: rtl/matrix4_vector_transform.sv
// Each word passes through the input register, multiply, pair add, full add, and shift and
// clip stages in turn.
// Throughput: one word per cycle; the pipeline moves as a whole and holds while the output
// word is stalled.
// Reset clears all valid bits and loads the identity matrix into the registers.
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// Fixed-point 4x4 matrix times vector, by rows or by columns per word,
// with Q16.16 results clipped to the signed 32-bit range.
// ----------------------------------------------------------------------------
module matrix4_vector_transform #(
  parameter int FRAC_BITS = 16,
  parameter int DIM       = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [m4vt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  m4vt_pkg::pair_t                   cfg_data,
  input  logic                              vec_valid,
  output logic                              vec_stall,
  input  m4vt_pkg::fix_t                    vec_x,
  input  m4vt_pkg::fix_t                    vec_y,
  input  m4vt_pkg::fix_t                    vec_z,
  input  m4vt_pkg::fix_t                    vec_w,
  input  logic                              use_columns,
  output logic                              res_valid,
  input  logic                              res_stall,
  output m4vt_pkg::fix_t                    res_x,
  output m4vt_pkg::fix_t                    res_y,
  output m4vt_pkg::fix_t                    res_z,
  output m4vt_pkg::fix_t                    res_w,
  output logic                              saturated
);
  import m4vt_pkg::*;

  matrix_t                entries;
  coef_t                  coef_next;
  coef_t                  coef;
  vec_t                   vec;
  vec_t                   res_arr;
  logic [COMP_COUNT-1:0]  sat_arr;
  logic [STAGE_COUNT-1:0] valid;
  logic                   advance;

  m4vt_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .entries   (entries)
  );

  // whole pipeline moves unless the output word is held
  assign advance   = !(valid[STAGE_COUNT-1] && res_stall);
  assign vec_stall = !advance;
  assign res_valid = valid[STAGE_COUNT-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (advance) begin
      valid <= {valid[STAGE_COUNT-2:0], vec_valid};
    end
  end

  // coefficient pick: row k, or column k when the word asks for columns
  always_comb begin
    for (int k = 0; k < COMP_COUNT; k++) begin
      for (int i = 0; i < COMP_COUNT; i++) begin
        if ((k < DIM) && (i < DIM)) begin
          coef_next[k][i] = use_columns ? entries[i*COMP_COUNT + k]
                                        : entries[k*COMP_COUNT + i];
        end else begin
          coef_next[k][i] = '0;
        end
      end
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (advance) begin
      vec  <= {vec_w, vec_z, vec_y, vec_x};
      coef <= coef_next;
    end
  end

  // one lane per live component
  for (genvar k = 0; k < COMP_COUNT; k++) begin : g_lane
    if (k < DIM) begin : g_live
      m4vt_dot_lane #(
        .FRAC_BITS (FRAC_BITS)
      ) u_lane (
        .clk     (clk),
        .advance (advance),
        .vec     (vec),
        .coef    (coef[k]),
        .res     (res_arr[k]),
        .sat     (sat_arr[k])
      );
    end else begin : g_unused
      assign res_arr[k] = '0;
      assign sat_arr[k] = 1'b0;
    end
  end

  assign res_x     = res_arr[0];
  assign res_y     = res_arr[1];
  assign res_z     = res_arr[2];
  assign res_w     = res_arr[3];
  assign saturated = |sat_arr;

  // valid bits shift by one place on every advance
  a_valid_shift: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(advance) |->
      valid[STAGE_COUNT-1:1] == $past(valid[STAGE_COUNT-2:0]))
    else $error("valid bits did not shift with the pipeline");

  // a held pipeline keeps its valid bits
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> valid == $past(valid))
    else $error("valid bits changed while the pipeline was held");

  // the fourth component stays zero in the three-dimensional case
  a_res_w_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (DIM == COMP_COUNT) || (res_w == '0))
    else $error("fourth component not zero in the 3D case");

  // a clipped word carries at least one component at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    res_valid && saturated |->
      res_x == FIX_MAX || res_x == FIX_MIN || res_y == FIX_MAX || res_y == FIX_MIN ||
      res_z == FIX_MAX || res_z == FIX_MIN || res_w == FIX_MAX || res_w == FIX_MIN)
    else $error("saturated set with no component at a limit");

endmodule

// File: tb/m4vt_checker.sv
// ----------------------------------------------------------------------------
// m4vt_checker
// Watches the register port and both word channels of the matrix-vector
// transform, keeps its own copy of the matrix, predicts each result word and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module m4vt_checker #(
  parameter int FRAC_BITS = 16,
  parameter int DIM       = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [m4vt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  m4vt_pkg::pair_t                cfg_data,
  input  logic                           vec_valid,
  input  logic                           vec_stall,
  input  m4vt_pkg::fix_t                 vec_x,
  input  m4vt_pkg::fix_t                 vec_y,
  input  m4vt_pkg::fix_t                 vec_z,
  input  m4vt_pkg::fix_t                 vec_w,
  input  logic                           use_columns,
  input  logic                           res_valid,
  input  logic                           res_stall,
  input  m4vt_pkg::fix_t                 res_x,
  input  m4vt_pkg::fix_t                 res_y,
  input  m4vt_pkg::fix_t                 res_z,
  input  m4vt_pkg::fix_t                 res_w,
  input  logic                           saturated,
  output int                             fail_count,
  output int                             pending,
  output int                             checked_count,
  output int                             clipped_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import m4vt_pkg::*;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
    fix_t w;
    logic sat;
  } vertex_t;

  pair_t   matrix_pairs [PAIR_COUNT];
  vertex_t expected_vertices [$];
  int      failures;
  int      checked;
  int      clipped;

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
    clipped_count = 0;
    failures      = 0;
    checked       = 0;
    clipped       = 0;
  end

  // entry e of the row-major matrix, two entries per register
  function automatic fix_t matrix_entry(input int e);
    pair_t pr;
    pr = matrix_pairs[e / 2];
    if (e % 2) return fix_t'(pr[PAIR_W-1:FIX_W]);
    return fix_t'(pr[FIX_W-1:0]);
  endfunction

  // dot products with rows or columns, floor shift, clip to 32 bits
  function automatic vertex_t transform_vertex(input fix_t vx, input fix_t vy,
                                               input fix_t vz, input fix_t vw,
                                               input logic cols);
    fix_t    vin  [COMP_COUNT];
    fix_t    vout [COMP_COUNT];
    vertex_t r;
    sum_t    acc;
    sum_t    q;
    prod_t   prod;
    int      e;
    vin[0] = vx;
    vin[1] = vy;
    vin[2] = vz;
    vin[3] = vw;
    r.sat  = 1'b0;
    for (int k = 0; k < COMP_COUNT; k++) begin
      vout[k] = '0;
      if (k < DIM) begin
        acc = '0;
        for (int i = 0; i < DIM; i++) begin
          e    = cols ? (i * COMP_COUNT + k) : (k * COMP_COUNT + i);
          prod = vin[i] * matrix_entry(e);
          acc  = acc + prod;
        end
        q = acc >>> FRAC_BITS;
        if (q > FIX_MAX) begin
          vout[k] = FIX_MAX;
          r.sat   = 1'b1;
        end else if (q < FIX_MIN) begin
          vout[k] = FIX_MIN;
          r.sat   = 1'b1;
        end else begin
          vout[k] = fix_t'(q);
        end
      end
    end
    r.x = vout[0];
    r.y = vout[1];
    r.z = vout[2];
    r.w = vout[3];
    return r;
  endfunction

  // register writes, prediction on input words, compare on result words
  always @(posedge clk) begin
    vertex_t seen;
    vertex_t want;
    if (rst) begin
      for (int p = 0; p < PAIR_COUNT; p++) matrix_pairs[p] = PAIR_RESET[p];
      expected_vertices.delete();
    end else begin
      if (cfg_write && cfg_index < PAIR_COUNT) begin
        matrix_pairs[cfg_index[PAIR_IDX_W-1:0]] = cfg_data;
      end
      if (res_valid && !res_stall) begin
        seen = '{res_x, res_y, res_z, res_w, saturated};
        if (expected_vertices.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("result word with nothing expected: %h %h %h %h sat %b",
                     seen.x, seen.y, seen.z, seen.w, seen.sat);
          end
        end else begin
          want = expected_vertices.pop_front();
          checked++;
          if (want.sat) clipped++;
          if (seen.x !== want.x || seen.y !== want.y || seen.z !== want.z ||
              seen.w !== want.w || seen.sat !== want.sat) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch on word %0d: expected %h %h %h %h sat %b", checked,
                       want.x, want.y, want.z, want.w, want.sat);
              $display("                       got %h %h %h %h sat %b",
                       seen.x, seen.y, seen.z, seen.w, seen.sat);
            end
          end
        end
      end
      if (vec_valid && !vec_stall) begin
        expected_vertices.push_back(transform_vertex(vec_x, vec_y, vec_z, vec_w,
                                                     use_columns));
      end
    end
    fail_count    <= failures;
    pending       <= expected_vertices.size();
    checked_count <= checked;
    clipped_count <= clipped;
  end

endmodule

// File: tb/tb_matrix4_vector_transform.sv
// ----------------------------------------------------------------------------
// tb_matrix4_vector_transform
// Drives vertices and matrix settings into the transform: a short directed
// set (identity, all-max, all-min, asymmetric matrix) then random phases with
// random matrices, random idle on both channels and one long output hold.
// ----------------------------------------------------------------------------
module tb_matrix4_vector_transform;
  timeunit 1ns;
  timeprecision 1ps;
  import m4vt_pkg::*;

  localparam int FRAC_BITS     = 16;
  localparam int DIM           = 4;
  localparam int RANDOM_PHASES = 5;
  localparam int RANDOM_ITEMS  = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 500000;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  pair_t                cfg_data    = '0;
  logic                 vec_valid   = 1'b0;
  logic                 vec_stall;
  fix_t                 vec_x       = '0;
  fix_t                 vec_y       = '0;
  fix_t                 vec_z       = '0;
  fix_t                 vec_w       = '0;
  logic                 use_columns = 1'b0;
  logic                 res_valid;
  logic                 res_stall   = 1'b0;
  fix_t                 res_x;
  fix_t                 res_y;
  fix_t                 res_z;
  fix_t                 res_w;
  logic                 saturated;

  int    fail_count;
  int    pending;
  int    checked_count;
  int    clipped_count;
  int    cycle_count    = 0;
  int    settings_count = 1;
  bit    send_burst     = 1'b0;
  bit    recv_burst     = 1'b0;
  bit    long_hold      = 1'b0;
  pair_t next_matrix [PAIR_COUNT];

  matrix4_vector_transform #(
    .FRAC_BITS(FRAC_BITS),
    .DIM      (DIM)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .vec_valid  (vec_valid),
    .vec_stall  (vec_stall),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .vec_z      (vec_z),
    .vec_w      (vec_w),
    .use_columns(use_columns),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_z      (res_z),
    .res_w      (res_w),
    .saturated  (saturated)
  );

  m4vt_checker #(
    .FRAC_BITS(FRAC_BITS),
    .DIM      (DIM)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .vec_valid    (vec_valid),
    .vec_stall    (vec_stall),
    .vec_x        (vec_x),
    .vec_y        (vec_y),
    .vec_z        (vec_z),
    .vec_w        (vec_w),
    .use_columns  (use_columns),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res_x        (res_x),
    .res_y        (res_y),
    .res_z        (res_z),
    .res_w        (res_w),
    .saturated    (saturated),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked_count(checked_count),
    .clipped_count(clipped_count)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // mostly small values, some full range, some corner values
  function automatic fix_t rand_fix();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return fix_t'($urandom);
    if (pick < 9) return fix_t'(int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
    case ($urandom_range(0, 5))
      0: return FIX_MAX;
      1: return FIX_MIN;
      2: return fix_t'(0);
      3: return fix_t'(-1);
      4: return fix_t'(32'sh0001_0000);
      default: return fix_t'(-32'sh0001_0000);
    endcase
  endfunction

  // offer one word after a random gap (none in burst mode), return once it is taken
  task automatic send_vertex(input fix_t x, input fix_t y, input fix_t z, input fix_t w,
                             input logic cols);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      vec_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vec_x       <= x;
    vec_y       <= y;
    vec_z       <= z;
    vec_w       <= w;
    use_columns <= cols;
    vec_valid   <= 1'b1;
    do @(posedge clk); while (vec_stall);
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic settle();
    vec_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (STAGE_COUNT) @(posedge clk);
  endtask

  // write all pairs back to back, then one write to an unused index
  task automatic load_matrix();
    for (int p = 0; p < PAIR_COUNT; p++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(p);
      cfg_data  <= next_matrix[p];
      @(posedge clk);
    end
    // unused index must leave the matrix alone
    cfg_index <= CFG_IDX_W'($urandom_range(PAIR_COUNT, 2**CFG_IDX_W - 1));
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_count++;
  endtask

  // receiver: random stall before each word, one long hold on request
  initial begin : receiver
    int unsigned wait_cycles;
    forever begin
      if (long_hold) begin
        wait_cycles = HOLD_CYCLES;
        long_hold   = 1'b0;
      end else begin
        wait_cycles = recv_burst ? 0 : $urandom_range(0, 15);
      end
      if (wait_cycles != 0) begin
        res_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        res_stall <= 1'b0;
      end
      do @(posedge clk); while (!(res_valid && !res_stall));
    end
  end

  initial begin : stimulus
    int phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // identity matrix out of reset, rows and columns
    send_vertex(fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0), 1'b0);
    send_vertex(FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, 1'b0);
    send_vertex(FIX_MIN, FIX_MAX, fix_t'(-1), fix_t'(1), 1'b1);
    send_vertex(fix_t'(32'sh0001_8000), fix_t'(-32'sh0002_4000), fix_t'(32'sh7FFF),
                fix_t'(-1), 1'b1);
    send_vertex(fix_t'(-1), fix_t'(-1), fix_t'(-1), fix_t'(-1), 1'b0);

    // every entry at the positive extreme: clipping both ways
    settle();
    for (int p = 0; p < PAIR_COUNT; p++) next_matrix[p] = {FIX_MAX, FIX_MAX};
    load_matrix();
    send_vertex(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, 1'b0);
    send_vertex(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, 1'b1);
    send_vertex(fix_t'(1), fix_t'(0), fix_t'(0), fix_t'(0), 1'b0);
    send_vertex(FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, 1'b1);

    // every entry at the negative extreme
    settle();
    for (int p = 0; p < PAIR_COUNT; p++) next_matrix[p] = {FIX_MIN, FIX_MIN};
    load_matrix();
    send_vertex(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, 1'b0);
    send_vertex(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, 1'b1);
    send_vertex(fix_t'(-1), fix_t'(0), fix_t'(0), fix_t'(0), 1'b0);
    send_vertex(fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0), 1'b1);

    // asymmetric matrix in quarter steps: rows differ from columns, floor on negatives
    settle();
    for (int p = 0; p < PAIR_COUNT; p++) begin
      next_matrix[p] = {fix_t'((2 * p - 6) * 32'sh4000), fix_t'((2 * p - 7) * 32'sh4000)};
    end
    load_matrix();
    send_vertex(fix_t'(-1), fix_t'(1), fix_t'(-3), fix_t'(5), 1'b0);
    send_vertex(fix_t'(-1), fix_t'(1), fix_t'(-3), fix_t'(5), 1'b1);
    send_vertex(fix_t'(32'sh0001_0000), fix_t'(32'sh0002_0000), fix_t'(-32'sh0003_0000),
                fix_t'(32'sh8000), 1'b0);
    send_vertex(fix_t'(32'sh0001_0000), fix_t'(32'sh0002_0000), fix_t'(-32'sh0003_0000),
                fix_t'(32'sh8000), 1'b1);
    send_vertex(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, 1'b0);

    // random matrices and vertices; one phase fills the pipe behind a long hold
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      for (int p = 0; p < PAIR_COUNT; p++) next_matrix[p] = {rand_fix(), rand_fix()};
      load_matrix();
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        send_burst = 1'b1;
        long_hold  = 1'b1;
      end
      repeat (RANDOM_ITEMS) begin
        send_vertex(rand_fix(), rand_fix(), rand_fix(), rand_fix(), 1'($urandom_range(0, 1)));
      end
    end

    settle();
    repeat (2 * STAGE_COUNT) @(posedge clk);
    $display("checked %0d vertices by rows and columns, %0d with clipping,", checked_count,
             clipped_count);
    $display("across %0d matrix settings including all-max and all-min entries",
             settings_count);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures, %0d words outstanding", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/m4vt_pkg.sv
rtl/m4vt_cfg_regs.sv
rtl/m4vt_dot_lane.sv
rtl/matrix4_vector_transform.sv
tb/m4vt_checker.sv
tb/tb_matrix4_vector_transform.sv
